// ----- design/banked_interrupt_controller_top_assert.svh -----
`ifndef BANKED_INTERRUPT_CONTROLLER_TOP_ASSERT_SVH
`define BANKED_INTERRUPT_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bic_pkg.sv -----
package bic_pkg;

  localparam int unsigned NUM_CORES_DEF = 4;
  localparam int unsigned MAX_CORES     = 4;
  localparam int unsigned NUM_BANKS     = 8;
  localparam int unsigned NUM_WORDS     = 3;

  localparam logic [31:0] W2_SOURCES  = 32'h0000_ffff;
  localparam logic [31:0] W2_SUM_LOW  = 32'h0100_0000;
  localparam logic [31:0] W2_SUM_MID  = 32'h0200_0000;
  localparam logic [31:0] W2_LINE     = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
  localparam logic [31:0] W2_WRITABLE = W2_SOURCES | W2_LINE;

  // word select value that names no register
  localparam logic [1:0] WORD_NONE  = 2'd3;
  localparam logic [1:0] WORD_TOP   = 2'd2;
  // line index bits 6..5 value past the last source word
  localparam logic [1:0] LINE_WORD_NONE = 2'd3;

  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    GRP_PENDING = 2'd0,
    GRP_SET_EN  = 2'd1,
    GRP_CLR_EN  = 2'd2,
    GRP_STATUS  = 2'd3
  } grp_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  word_address;
    logic [31:0] write_data;
    logic [6:0]  line_index;
    logic        line_level;
  } item_t;

  typedef struct packed {
    logic       line_wr;
    logic       en_set;
    logic       en_clr;
    logic       rd_pend;
    logic       rd_en;
    logic       rd_stat;
    logic       bad;
    logic [2:0] bank;
    logic [1:0] word;
  } dec_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  irq_lines;
    logic [3:0]  fiq_lines;
    logic        bad_access;
  } result_t;

endpackage

// ----- design/bic_if.sv -----
interface bic_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [6:0]  word_address;
  logic [31:0] write_data;
  logic [6:0]  line_index;
  logic        line_level;

  modport source (output valid, kind, word_address, write_data, line_index, line_level,
                  input ready);
  modport sink   (input valid, kind, word_address, write_data, line_index, line_level,
                  output ready);
endinterface

interface bic_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [3:0]  irq_lines;
  logic [3:0]  fiq_lines;
  logic        bad_access;

  modport source (output valid, read_data, irq_lines, fiq_lines, bad_access,
                  input ready);
  modport sink   (input valid, read_data, irq_lines, fiq_lines, bad_access,
                  output ready);
endinterface

// ----- design/bic_decode.sv -----
module bic_decode
  import bic_pkg::*;
#(
  parameter int unsigned NUM_CORES = NUM_CORES_DEF
) (
  input  item_t item,
  output dec_t  dec
);

  logic [2:0] bank;
  logic [1:0] word;
  logic [1:0] grp;
  logic       exists;
  logic       word_ok;
  logic       is_read;
  logic       is_write;

  assign bank     = item.word_address[6:4];
  assign word     = item.word_address[1:0];
  assign grp      = item.word_address[3:2];
  assign exists   = {1'b0, bank[1:0]} < 3'(NUM_CORES);
  assign word_ok  = word != WORD_NONE;
  assign is_read  = item.kind == KIND_READ;
  assign is_write = item.kind == KIND_WRITE;

  always_comb begin
    dec         = '0;
    dec.bank    = bank;
    dec.word    = word;
    dec.line_wr = (item.kind == KIND_LINE) && (item.line_index[6:5] != LINE_WORD_NONE);
    if (is_read) begin
      if (!word_ok || !exists) begin
        dec.bad = 1'b1;
      end else begin
        unique case (grp_t'(grp))
          GRP_PENDING: dec.rd_pend = 1'b1;
          GRP_SET_EN,
          GRP_CLR_EN:  dec.rd_en   = 1'b1;
          GRP_STATUS: begin
            if (bank == 3'd0) dec.rd_stat = 1'b1;
            else              dec.bad     = 1'b1;
          end
        endcase
      end
    end else if (is_write) begin
      if (!word_ok || !exists || grp == GRP_PENDING || grp == GRP_STATUS) begin
        dec.bad = 1'b1;
      end else begin
        dec.en_set = grp == GRP_SET_EN;
        dec.en_clr = grp == GRP_CLR_EN;
      end
    end
  end

endmodule

// ----- design/bic_regs.sv -----
module bic_regs
  import bic_pkg::*;
#(
  parameter int unsigned NUM_CORES = NUM_CORES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    go,
  input  item_t   item,
  input  dec_t    dec,
  output result_t res
);

  logic [31:0] lvl_r   [NUM_WORDS];
  logic [31:0] lvl_nxt [NUM_WORDS];
  logic [31:0] en_w    [NUM_BANKS][NUM_WORDS];
  logic [31:0] en_nxt  [NUM_BANKS][NUM_WORDS];
  logic [31:0] m_cur   [NUM_BANKS][NUM_WORDS];
  logic [31:0] m_nxt   [NUM_BANKS][NUM_WORDS];
  logic [31:0] wmask;
  logic [NUM_BANKS-1:0] act_nxt;

  assign wmask = item.write_data & ((dec.word == WORD_TOP) ? W2_WRITABLE : ALL_ONES);

  // source levels
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      lvl_nxt[w] = lvl_r[w];
    end
    if (go && dec.line_wr) begin
      lvl_nxt[item.line_index[6:5]][item.line_index[4:0]] = item.line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NUM_WORDS; w++) lvl_r[w] <= '0;
    end else begin
      for (int w = 0; w < NUM_WORDS; w++) lvl_r[w] <= lvl_nxt[w];
    end
  end

  // enable words, stored only for banks of present cores
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    if ((b % MAX_CORES) < NUM_CORES) begin : g_present
      logic [31:0] en_r [NUM_WORDS];
      for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
        logic hit;
        assign hit = go && (dec.bank == 3'(b)) && (dec.word == 2'(w));
        assign en_w[b][w] = en_r[w];
        always_comb begin
          en_nxt[b][w] = en_r[w];
          if (hit && dec.en_set) en_nxt[b][w] = en_r[w] | wmask;
          if (hit && dec.en_clr) en_nxt[b][w] = en_r[w] & ~wmask;
        end
        always_ff @(posedge clk) begin
          if (!rst_n) en_r[w] <= '0;
          else        en_r[w] <= en_nxt[b][w];
        end
      end
    end else begin : g_absent
      for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
        assign en_w[b][w]   = '0;
        assign en_nxt[b][w] = '0;
      end
    end
  end

  // masked words, before and after this transaction
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        m_cur[b][w] = lvl_r[w] & en_w[b][w];
        m_nxt[b][w] = lvl_nxt[w] & en_nxt[b][w];
        if (w == NUM_WORDS - 1) begin
          m_cur[b][w] = m_cur[b][w] & W2_SOURCES;
          m_nxt[b][w] = m_nxt[b][w] & W2_SOURCES;
        end
      end
      act_nxt[b] = |{m_nxt[b][0], m_nxt[b][1], m_nxt[b][2]};
    end
  end

  always_comb begin
    res            = '0;
    res.bad_access = dec.bad;
    res.irq_lines  = act_nxt[3:0];
    res.fiq_lines  = act_nxt[7:4];
    if (dec.rd_pend) begin
      res.read_data = m_cur[dec.bank][dec.word];
      if (dec.word == WORD_TOP) begin
        if (|m_cur[dec.bank][0]) res.read_data = res.read_data | W2_SUM_LOW;
        if (|m_cur[dec.bank][1]) res.read_data = res.read_data | W2_SUM_MID;
        // copy of the bank output line
        if (|{m_cur[dec.bank][0], m_cur[dec.bank][1], m_cur[dec.bank][2]}) begin
          res.read_data = res.read_data | W2_LINE;
        end
      end
    end else if (dec.rd_en) begin
      res.read_data = en_w[dec.bank][dec.word];
    end else if (dec.rd_stat) begin
      res.read_data = lvl_r[dec.word];
    end
  end

endmodule

// ----- design/banked_interrupt_controller_top.sv -----
// Level-sensitive interrupt controller for 80 source lines and eight register
// banks (IRQ banks 0..3 and FIQ banks 4..7, one of each per core). Every
// transaction on the input channel is a line change, a register read or a
// register write, and gives exactly one result transaction carrying the read
// data, the bad-offset flag and the per-core IRQ and FIQ lines as they stand
// after that transaction. Each transaction passes the input register, then
// decode/update/read into the result register; throughput is one transaction
// per cycle unless the result channel stalls, set by the single update of the
// enable and level flops per cycle. Banks of cores at or above NUM_CORES have
// no storage, read as bad offsets and drive zero output bits.
module banked_interrupt_controller_top
  import bic_pkg::*;
#(
  parameter int unsigned NUM_CORES = NUM_CORES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  bic_in_if.sink          in_if,
  bic_out_if.source       out_if
);

`include "banked_interrupt_controller_top_assert.svh"

  localparam logic [3:0] CORE_MASK = 4'((1 << NUM_CORES) - 1);

  // input register stage
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  item_t   s1_item_r;
  item_t   s1_item_nxt;
  logic    s1_go;
  logic    in_take;

  // result register stage
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;
  result_t out_res_nxt;

  dec_t    dec;
  result_t res;

  // stage 1 moves on whenever the result register is empty or being drained
  assign s1_go    = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_go;
  assign in_take  = in_if.valid && in_if.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_take) begin
      s1_valid_nxt             = 1'b1;
      s1_item_nxt.kind         = in_if.kind;
      s1_item_nxt.word_address = in_if.word_address;
      s1_item_nxt.write_data   = in_if.write_data;
      s1_item_nxt.line_index   = in_if.line_index;
      s1_item_nxt.line_level   = in_if.line_level;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  // address and kind decode
  bic_decode #(
    .NUM_CORES (NUM_CORES)
  ) u_decode (
    .item (s1_item_r),
    .dec  (dec)
  );

  // level and enable state, register read mux, bank outputs
  bic_regs #(
    .NUM_CORES (NUM_CORES)
  ) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (s1_go),
    .item  (s1_item_r),
    .dec   (dec),
    .res   (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.read_data  = out_res_r.read_data;
  assign out_if.irq_lines  = out_res_r.irq_lines;
  assign out_if.fiq_lines  = out_res_r.fiq_lines;
  assign out_if.bad_access = out_res_r.bad_access;

  // a bad offset never returns data
  `BIC_ASSERT_NOW(a_bad_reads_zero, out_valid_r && out_res_r.bad_access,
                  out_res_r.read_data == '0, "bad access carries read data")

  // absent cores keep their output lines low
  `BIC_ASSERT_NOW(a_absent_cores_low, out_valid_r,
                  ((out_res_r.irq_lines | out_res_r.fiq_lines) & ~CORE_MASK) == '0,
                  "output line set for an absent core")

  // a held item in stage 1 is not lost or altered
  `BIC_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_go,
                   s1_valid_r && $stable(s1_item_r), "stalled item lost or changed")

  // every item leaving stage 1 lands in the result register
  `BIC_ASSERT_NEXT(a_s1_to_out, s1_go, out_valid_r, "result missing after issue")

endmodule
